>>> rtl/tssm_pkg.sv
//------------------------------------------------------------------------------
// Touch sample mapper package
// Shared types, register indexes and sizes for the touch sample mapper.
//------------------------------------------------------------------------------
`default_nettype none
package tssm_pkg;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   localparam logic [2:0] REG_CXX    = 3'd0;
   localparam logic [2:0] REG_CXY    = 3'd1;
   localparam logic [2:0] REG_OFFX   = 3'd2;
   localparam logic [2:0] REG_CYX    = 3'd3;
   localparam logic [2:0] REG_CYY    = 3'd4;
   localparam logic [2:0] REG_OFFY   = 3'd5;
   localparam logic [2:0] REG_DIV    = 3'd6;
   localparam logic [2:0] REG_ORIENT = 3'd7;

   typedef struct packed {
      logic [7:0] z1_reading;
      logic [7:0] z2_reading;
      logic [9:0] x_sample0;
      logic [9:0] x_sample1;
      logic [9:0] x_sample2;
      logic [9:0] x_sample3;
      logic [9:0] y_sample0;
      logic [9:0] y_sample1;
      logic [9:0] y_sample2;
      logic [9:0] y_sample3;
   } req_type;

   typedef struct packed {
      logic [8:0] screen_x;
      logic [8:0] screen_y;
      logic [7:0] touch_pressure;
      logic [9:0] kept_raw_x;
      logic [9:0] kept_raw_y;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic axis_y;
      logic mul_a;
      logic mul_b;
      logic div_start;
      logic div_step;
      logic commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_x;
      logic need_y;
      logic div_last;
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/tssm_datapath.sv
//------------------------------------------------------------------------------
// Touch sample mapper datapath
// Averaging, affine numerator, shared restoring divider and rotation.
//------------------------------------------------------------------------------
`default_nettype none
module tssm_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_write_data,
   input  wire tssm_pkg::req_type req_data,
   input  wire tssm_pkg::cmd_type cmd,
   output tssm_pkg::sts_type      sts,
   output tssm_pkg::rsp_type      rsp_data
);
   logic signed [31:0] cxx_ff, cxy_ff, offx_ff, cyx_ff, cyy_ff, offy_ff, div_ff;
   logic [1:0] orient_ff;
   logic [9:0] raw_x_ff, raw_y_ff, last_x_ff, last_y_ff, raw_x_in, raw_y_in;
   logic [8:0] map_x_ff;
   logic [7:0] map_y_ff, press_ff, press_in;
   logic signed [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   tssm_pkg::rsp_type rsp_ff, rsp_in;
   logic [11:0] sum_x, sum_y;
   logic [7:0] p;
   logic [9:0] ax, ay;
   logic signed [31:0] ca, cb;
   logic signed [63:0] prod;
   logic [63:0] num_mag;
   logic [31:0] div_mag;
   logic [32:0] trial;
   logic [63:0] qs;
   logic [8:0] clamped, sx, sy;
   logic [8:0] my9;

   always_comb begin
      p = req_data.z1_reading + (8'd127 - req_data.z2_reading);
      sum_x = 12'd4092 - 12'(req_data.x_sample0) - 12'(req_data.x_sample1)
            - 12'(req_data.x_sample2) - 12'(req_data.x_sample3);
      sum_y = 12'(req_data.y_sample0) + 12'(req_data.y_sample1)
            + 12'(req_data.y_sample2) + 12'(req_data.y_sample3);
      ax = sum_x[11:2];
      ay = sum_y[11:2];
      press_in = p;
      raw_x_in = raw_x_ff;
      raw_y_in = raw_y_ff;
      if (p < 8'd5) begin
         press_in = 8'd0;
      end else if (ax >= 10'd10 && ay >= 10'd10) begin
         raw_x_in = ax;
         raw_y_in = ay;
      end
   end

   always_comb begin
      ca = cmd.axis_y ? cyx_ff : cxx_ff;
      cb = cmd.axis_y ? cyy_ff : cxy_ff;
      if (cmd.mul_a) prod = ca * $signed({22'd0, raw_x_ff});
      else           prod = cb * $signed({22'd0, raw_y_ff});
      num_mag = num_ff[63] ? 64'(-num_ff) : num_ff;
      div_mag = div_ff[31] ? 32'(-div_ff) : div_ff;
      trial = {rem_ff[31:0], quo_ff[63]} - {1'b0, div_mag};
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.mul_a) begin
         num_in = prod + 64'(cmd.axis_y ? offy_ff : offx_ff);
      end else if (cmd.mul_b) begin
         num_in = num_ff + prod;
      end else if (cmd.div_start) begin
         quo_in = num_mag;
         rem_in = 33'd0;
         neg_in = num_ff[63] ^ div_ff[31];
         cnt_in = '0;
      end else if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_comb begin
      qs = neg_ff ? 64'(-quo_ff) : quo_ff;
      if (div_ff == 32'sd0 || qs[63]) clamped = 9'd0;
      else if (cmd.axis_y)
         clamped = (qs >= 64'(tssm_pkg::SCREEN_HEIGHT))
                   ? 9'(tssm_pkg::SCREEN_HEIGHT - 1) : qs[8:0];
      else
         clamped = (qs >= 64'(tssm_pkg::SCREEN_WIDTH))
                   ? 9'(tssm_pkg::SCREEN_WIDTH - 1) : qs[8:0];
      my9 = {1'b0, map_y_ff};
      case (orient_ff)
         2'd0: begin
            sx = map_x_ff;
            sy = my9;
         end
         2'd1: begin
            sx = my9;
            sy = 9'(tssm_pkg::SCREEN_WIDTH) - map_x_ff;
         end
         2'd2: begin
            sx = 9'(tssm_pkg::SCREEN_WIDTH) - map_x_ff;
            sy = 9'(tssm_pkg::SCREEN_HEIGHT) - my9;
         end
         default: begin
            sx = 9'(tssm_pkg::SCREEN_HEIGHT) - my9;
            sy = map_x_ff;
         end
      endcase
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.screen_x = sx;
         rsp_in.screen_y = sy;
         rsp_in.touch_pressure = press_ff;
         rsp_in.kept_raw_x = raw_x_ff;
         rsp_in.kept_raw_y = raw_y_ff;
      end
   end

   assign sts.need_x = raw_x_ff != last_x_ff;
   assign sts.need_y = raw_y_ff != last_y_ff;
   assign sts.div_last = cnt_ff == 6'd63;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         cxx_ff <= '0; cxy_ff <= '0; offx_ff <= '0;
         cyx_ff <= '0; cyy_ff <= '0; offy_ff <= '0;
         div_ff <= '0; orient_ff <= '0;
         raw_x_ff <= '0; raw_y_ff <= '0; last_x_ff <= '0; last_y_ff <= '0;
         map_x_ff <= '0; map_y_ff <= '0; press_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               tssm_pkg::REG_CXX:  cxx_ff  <= csr_write_data;
               tssm_pkg::REG_CXY:  cxy_ff  <= csr_write_data;
               tssm_pkg::REG_OFFX: offx_ff <= csr_write_data;
               tssm_pkg::REG_CYX:  cyx_ff  <= csr_write_data;
               tssm_pkg::REG_CYY:  cyy_ff  <= csr_write_data;
               tssm_pkg::REG_OFFY: offy_ff <= csr_write_data;
               tssm_pkg::REG_DIV:  div_ff  <= csr_write_data;
               default:            orient_ff <= csr_write_data[1:0];
            endcase
         end
         if (cmd.load) begin
            raw_x_ff <= raw_x_in;
            raw_y_ff <= raw_y_in;
            press_ff <= press_in;
         end
         if (cmd.commit) begin
            if (cmd.axis_y) begin
               map_y_ff <= clamped[7:0];
               last_y_ff <= raw_y_ff;
            end else begin
               map_x_ff <= clamped;
               last_x_ff <= raw_x_ff;
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> rtl/tssm_controller.sv
//------------------------------------------------------------------------------
// Touch sample mapper controller
// Sequences load, per-axis multiply, division, commit and output.
//------------------------------------------------------------------------------
`default_nettype none
module tssm_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire tssm_pkg::sts_type sts,
   output tssm_pkg::cmd_type      cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MULA = 3'd1;
   localparam logic [2:0] S_MULB = 3'd2;
   localparam logic [2:0] S_DSTA = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_COMM = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic axis_ff, axis_in, valid_ff, valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd = '0;
      cmd.axis_y = axis_ff;
      state_in = state_ff;
      axis_in = axis_ff;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MULA;
               axis_in = 1'b0;
            end
         end
         S_MULA: begin
            if ((axis_ff ? sts.need_y : sts.need_x)) begin
               cmd.mul_a = 1'b1;
               state_in = S_MULB;
            end else if (axis_ff) begin
               state_in = S_OUT;
            end else begin
               axis_in = 1'b1;
            end
         end
         S_MULB: begin
            cmd.mul_b = 1'b1;
            state_in = S_DSTA;
         end
         S_DSTA: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_COMM;
         end
         S_COMM: begin
            cmd.commit = 1'b1;
            if (axis_ff) state_in = S_OUT;
            else begin
               axis_in = 1'b1;
               state_in = S_MULA;
            end
         end
         S_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/touch_sample_to_screen_mapper.sv
//------------------------------------------------------------------------------
// Touch sample to screen mapper
// A new word is accepted only when the previous one has been mapped; each changed
// axis is remapped through the shared 64-step divider, an unchanged axis is not.
// The result register holds a word while the next is computed.
// Synchronous reset clears registers, kept point and mapping state.
//------------------------------------------------------------------------------
`default_nettype none
module touch_sample_to_screen_mapper (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tssm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tssm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_write_data
);
   tssm_pkg::cmd_type cmd;
   tssm_pkg::sts_type sts;

   tssm_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   tssm_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

>>> rtl/tssm_checker.sv
//------------------------------------------------------------------------------
// Touch sample mapper checker
// Port-level properties of the mapper, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module tssm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tssm_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a word while busy");
   a_no_rsp_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result word too early");
   a_pressure_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.touch_pressure == 8'd0 || rsp_data.touch_pressure >= 8'd5)
      else $error("pressure below threshold reported");
endmodule

bind touch_sample_to_screen_mapper tssm_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

>>> tb/tb.sv
//------------------------------------------------------------------------------
// Touch sample mapper testbench
// Drives touch measurements through the mapper with random idling on both
// channels, predicts each result word from a model of the pressure filter,
// averaging, stale-axis affine mapping and rotation, and compares each field.
//------------------------------------------------------------------------------
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tssm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tssm_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [2:0]        csr_index;
   logic [31:0]       csr_write_data;

   touch_sample_to_screen_mapper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   logic signed [31:0] cal_coef [0:5];
   logic signed [31:0] cal_divisor;
   logic [1:0]         cal_orient;
   logic [9:0]         kept_x, kept_y, mapped_from_x, mapped_from_y;
   logic [8:0]         screen_map_x, screen_map_y;

   tssm_pkg::rsp_type expected_words [$];
   int      mismatch_count;
   bit      calm;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [8:0] map_axis(logic signed [31:0] cx, logic signed [31:0] cy,
                                           logic signed [31:0] off, int limit);
      logic signed [63:0] num, q;
      num = 64'(cx) * $signed({54'd0, kept_x}) + 64'(cy) * $signed({54'd0, kept_y})
            + 64'(off);
      q = (cal_divisor == 0) ? 64'sd0 : num / 64'(cal_divisor);
      if (q < 0) q = 0;
      else if (q >= limit) q = limit - 1;
      return q[8:0];
   endfunction

   function automatic tssm_pkg::rsp_type predict_touch(tssm_pkg::req_type t);
      tssm_pkg::rsp_type r;
      logic [7:0]  p;
      logic [11:0] ax, ay;
      p = t.z1_reading + (8'd127 - t.z2_reading);
      if (p >= 5) begin
         ax = 12'(1023 - t.x_sample0) + 12'(1023 - t.x_sample1)
              + 12'(1023 - t.x_sample2) + 12'(1023 - t.x_sample3);
         ay = 12'(t.y_sample0) + t.y_sample1 + t.y_sample2 + t.y_sample3;
         if (ax[11:2] >= 10 && ay[11:2] >= 10) begin
            kept_x = ax[11:2];
            kept_y = ay[11:2];
         end
      end else
         p = 0;
      if (kept_x != mapped_from_x) begin
         mapped_from_x = kept_x;
         screen_map_x = map_axis(cal_coef[0], cal_coef[1], cal_coef[2],
                                 tssm_pkg::SCREEN_WIDTH);
      end
      if (kept_y != mapped_from_y) begin
         mapped_from_y = kept_y;
         screen_map_y = map_axis(cal_coef[3], cal_coef[4], cal_coef[5],
                                 tssm_pkg::SCREEN_HEIGHT);
      end
      case (cal_orient)
         2'd0: begin r.screen_x = screen_map_x; r.screen_y = screen_map_y; end
         2'd1: begin r.screen_x = screen_map_y; r.screen_y = 9'(320 - screen_map_x); end
         2'd2: begin
            r.screen_x = 9'(320 - screen_map_x);
            r.screen_y = 9'(240 - screen_map_y);
         end
         default: begin r.screen_x = 9'(240 - screen_map_y); r.screen_y = screen_map_x; end
      endcase
      r.touch_pressure = p;
      r.kept_raw_x = kept_x;
      r.kept_raw_y = kept_y;
      return r;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 29);
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= idle_now();
   end

   always @(posedge clock) begin
      tssm_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.screen_x !== e.screen_x || rsp_data.screen_y !== e.screen_y
                || rsp_data.touch_pressure !== e.touch_pressure
                || rsp_data.kept_raw_x !== e.kept_raw_x
                || rsp_data.kept_raw_y !== e.kept_raw_y) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected x=%0d y=%0d p=%0d rx=%0d ry=%0d, got x=%0d y=%0d p=%0d rx=%0d ry=%0d",
                           e.screen_x, e.screen_y, e.touch_pressure, e.kept_raw_x,
                           e.kept_raw_y, rsp_data.screen_x, rsp_data.screen_y,
                           rsp_data.touch_pressure, rsp_data.kept_raw_x,
                           rsp_data.kept_raw_y);
            end
         end
      end
   end

   task automatic send_touch(tssm_pkg::req_type t);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      expected_words.push_back(predict_touch(t));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == tssm_pkg::REG_DIV) cal_divisor = value;
      else if (idx == tssm_pkg::REG_ORIENT) cal_orient = value[1:0];
      else cal_coef[idx] = value;
   endtask

   function automatic tssm_pkg::req_type make_touch(int px, int py, bit firm);
      tssm_pkg::req_type t;
      t = tssm_pkg::req_type'({$urandom, $urandom, $urandom});
      if (firm) begin
         t.z2_reading = $urandom_range(100);
         t.z1_reading = $urandom_range(120);
      end
      if (px >= 0) begin
         t.x_sample0 = 10'(1023 - px); t.x_sample1 = 10'(1023 - px);
         t.x_sample2 = 10'(1023 - px); t.x_sample3 = 10'(1023 - px);
      end
      if (py >= 0) begin
         t.y_sample0 = 10'(py); t.y_sample1 = 10'(py);
         t.y_sample2 = 10'(py); t.y_sample3 = 10'(py);
      end
      return t;
   endfunction

   // Variant 0 is the typical calibration: about 320/1000 on x and 240/1000 on y.
   task automatic write_calibration(int variant);
      logic [31:0] v [0:7];
      case (variant)
         0: v = '{32'd320, 32'd0, 32'd0, 32'd0, 32'd240, 32'd0, 32'd1000, 32'd0};
         1: v = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'd3};
         2: v = '{-32'sd320, 32'd15, 32'd400000, 32'd12, -32'sd240, 32'd300000,
                  32'd1000, 32'd1};
         3: v = '{32'd320, 32'd0, 32'd0, 32'd0, 32'd240, 32'd0, 32'd0, 32'd2};
         4: v = '{32'hffffffff, 32'd1, 32'd0, 32'd1, 32'hffffffff, 32'd0,
                  32'hffffffff, 32'd0};
         default: for (int i = 0; i < 8; i++) v[i] = $urandom;
      endcase
      for (int i = 0; i < 8; i++) write_register(3'(i), v[i]);
   endtask

   task automatic test_directed();
      tssm_pkg::req_type t;
      write_calibration(0);
      send_touch(make_touch(500, 500, 1));
      t = make_touch(600, 600, 0); t.z1_reading = 0; t.z2_reading = 127;
      send_touch(t);                         // low pressure keeps the point
      t.z1_reading = 8'd255; t.z2_reading = 8'd0; send_touch(t);    // wrapped sum
      t.z1_reading = 8'd5; t.z2_reading = 8'd127; send_touch(t);    // threshold
      send_touch(make_touch(9, 500, 1));     // rejected sample
      send_touch(make_touch(500, 9, 1));
      send_touch(make_touch(10, 10, 1));
      send_touch(make_touch(1023, 1023, 1));
      t = make_touch(-1, -1, 1);
      t.x_sample0 = 0; t.x_sample1 = 10'h3ff; t.x_sample2 = 1; t.x_sample3 = 10'h2aa;
      t.y_sample0 = 10'h155; t.y_sample1 = 10'h3ff; t.y_sample2 = 0; t.y_sample3 = 3;
      send_touch(t);
      for (int c = 1; c < 6; c++) begin
         drain_results();
         write_calibration(c);
         send_touch(make_touch(1023, 1023, 1));   // full-scale point, remapped under the new calibration
         send_touch(make_touch(20 + c, 700, 1));
         send_touch(make_touch(900, 11 + c, 1));
         send_touch(make_touch(0, 0, 0));
      end
      drain_results();
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         write_calibration(phase == 0 ? 0 : (phase == 5 ? 2 : 9));
         write_register(tssm_pkg::REG_ORIENT, 32'(phase[1:0]));
         calm = (phase == 3);
         for (int n = 0; n < 215; n++) begin
            case ($urandom_range(9))
               0, 1: send_touch(make_touch(-1, -1, 0));
               2: send_touch(make_touch(kept_x, kept_y, 1));
               default: send_touch(make_touch($urandom_range(1023),
                                               $urandom_range(1023), 1));
            endcase
         end
         calm = 0;
      end
      drain_results();
   endtask

   initial begin
      reset = 1; req_valid = 0; req_data = '0; rsp_stall = 0;
      csr_write_enable = 0; csr_index = '0; csr_write_data = '0;
      mismatch_count = 0; calm = 0;
      for (int i = 0; i < 6; i++) cal_coef[i] = 0;
      cal_divisor = 0; cal_orient = 0;
      kept_x = 0; kept_y = 0; mapped_from_x = 0; mapped_from_y = 0;
      screen_map_x = 0; screen_map_y = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random();
      repeat (150) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
